// ===== rtl/pwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_pkg
// Shared types and constants for the post/wait match table.
// ----------------------------------------------------------------------------
package pwm_pkg;

    // Number of cells in the table and the width of the fill count.
    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        OP_POST          = 2'd0,
        OP_WAIT_ANY      = 2'd1,
        OP_WAIT_NODE     = 2'd2,
        OP_WAIT_NODE_TAG = 2'd3
    } op_t;

    // Status codes carried by a result item.
    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // One table entry.
    typedef struct packed {
        logic [15:0] node;
        logic [31:0] tag;
    } entry_t;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic capture;   // latch the compare result of the arriving item
        logic occupied;  // cell lies below the fill count
        logic use_tag;   // compare the tag as well as the node
        logic load;      // write the posted entry into this cell
        logic shift_en;  // compaction of a removed entry is under way
    } cell_ctrl_t;

endpackage

// ===== rtl/pwm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_cell
// One slot of the table: holds an entry, compares it with an arriving wait
// and takes its upper neighbor's entry when the table closes a gap.
// ----------------------------------------------------------------------------
module pwm_cell (
    input  logic                aclk,
    input  pwm_pkg::cell_ctrl_t ctrl,
    input  pwm_pkg::entry_t     req_in,     // entry of the arriving item
    input  pwm_pkg::entry_t     post_in,    // entry to store on a post
    input  pwm_pkg::entry_t     upper_in,   // entry of the next newer cell
    input  logic                above_in,   // some newer cell matched
    output pwm_pkg::entry_t     data_out,
    output logic                above_out
);

    pwm_pkg::entry_t data_reg;
    logic            match_reg;
    logic            match_next;
    logic            shift;

    // Compare against the arriving item.
    always_comb begin
        match_next = ctrl.occupied && (data_reg.node == req_in.node) &&
                     (!ctrl.use_tag || (data_reg.tag == req_in.tag));
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            match_reg <= match_next;
        end
    end

    // The newest match and every cell above it move down by one place.
    assign shift = ctrl.shift_en && !above_in;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            data_reg <= post_in;
        end else if (shift) begin
            data_reg <= upper_in;
        end
    end

    assign data_out  = data_reg;
    assign above_out = above_in | match_reg;

endmodule

// ===== rtl/post_wait_match_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// post_wait_match_table
// Table of pending post notifications matched by wait items.
// ----------------------------------------------------------------------------
// The s_ channel takes one item: an operation, a node and a tag. A post
// appends an entry; a wait removes the newest entry of any kind, the newest
// with the given node, or the newest with the given node and tag. The m_
// channel returns one item per input: a status and the entry count after it.
//
// Each item passes through its cycle of acceptance, in which every cell
// compares its entry with the item, and an execute state in which the match
// flag ripples down the cell chain, the cells above the newest match shift
// down by one and the result register loads. The result is valid on the
// cycle after the execute state, the first cycle a new item can be accepted.
//
// If the receiver stalls, the finished result waits in the output register
// and the next item is accepted and compared, but it stays in its execute
// cycle until the waiting result is taken.
//
// Reset clears the fill count and the handshake state; the cell contents
// are left as they are, since only cells below the count are ever read.
// ----------------------------------------------------------------------------
module post_wait_match_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [15:0] s_node,
    input  logic [31:0] s_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [6:0]  m_entries_held
);

    localparam int DEPTH = pwm_pkg::TABLE_DEPTH;
    localparam int CW    = pwm_pkg::CNT_W;

    pwm_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    pwm_pkg::op_t       op_reg;
    pwm_pkg::entry_t    req_reg;
    pwm_pkg::entry_t    req_in;
    logic               m_valid_reg, m_valid_next;
    pwm_pkg::status_t   status_reg, status_next;
    logic [6:0]         held_reg, held_next;

    logic               accept;
    logic               advance;
    logic               full;
    logic               found;
    logic               shift_en;
    logic               post_load;

    pwm_pkg::entry_t    cell_data  [DEPTH+1];
    logic               cell_above [DEPTH+1];

    assign accept = s_valid && s_ready;
    assign req_in = '{node: s_node, tag: s_tag};
    assign full   = (count_reg == CW'(DEPTH));

    // Hold the accepted item for the execute cycle.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= pwm_pkg::op_t'(s_operation);
            req_reg <= req_in;
        end
    end

    // Chain of cells; the top of the chain is fed the held item.
    assign cell_data[DEPTH]  = req_reg;
    assign cell_above[DEPTH] = 1'b0;
    assign found             = cell_above[0];

    assign shift_en  = advance && found &&
                       ((op_reg == pwm_pkg::OP_WAIT_NODE) ||
                        (op_reg == pwm_pkg::OP_WAIT_NODE_TAG));
    assign post_load = advance && (op_reg == pwm_pkg::OP_POST) && !full;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        pwm_pkg::cell_ctrl_t ctrl;

        always_comb begin
            ctrl.capture  = accept;
            ctrl.occupied = (CW'(k) < count_reg);
            ctrl.use_tag  = (pwm_pkg::op_t'(s_operation) == pwm_pkg::OP_WAIT_NODE_TAG);
            ctrl.load     = post_load && (count_reg == CW'(k));
            ctrl.shift_en = shift_en;
        end

        pwm_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .req_in    (req_in),
            .post_in   (req_reg),
            .upper_in  (cell_data[k+1]),
            .above_in  (cell_above[k+1]),
            .data_out  (cell_data[k]),
            .above_out (cell_above[k])
        );
    end

    // Sequencer state and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pwm_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg <= status_next;
            held_reg   <= held_next;
        end
    end

    // Next state, count update and result of the executing item.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = pwm_pkg::ST_DONE;
        s_ready      = 1'b0;
        advance      = 1'b0;

        unique case (op_reg)
            pwm_pkg::OP_POST: begin
                if (full) begin
                    status_next = pwm_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + CW'(1);
                end
            end
            pwm_pkg::OP_WAIT_ANY: begin
                if (count_reg == '0) begin
                    status_next = pwm_pkg::ST_NONE;
                end else begin
                    count_next = count_reg - CW'(1);
                end
            end
            default: begin
                if (found) begin
                    count_next = count_reg - CW'(1);
                end else begin
                    status_next = pwm_pkg::ST_NONE;
                end
            end
        endcase
        held_next = 7'(count_next);

        unique case (state_reg)
            pwm_pkg::S_IDLE: begin
                count_next = count_reg;
                s_ready    = 1'b1;
                if (s_valid) begin
                    state_next = pwm_pkg::S_EXEC;
                end
            end
            pwm_pkg::S_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    advance      = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = pwm_pkg::S_IDLE;
                end else begin
                    count_next = count_reg;
                end
            end
            default: begin
                count_next = count_reg;
                state_next = pwm_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_entries_held = held_reg;

    // The fill count never passes the table depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("fill count exceeds table depth");

    // A rejected post is shown only while the table is full.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == pwm_pkg::ST_FULL)) |-> full)
        else $error("full status with room in the table");

    // A matched node wait removes exactly one entry.
    a_match_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        shift_en |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("matched wait did not remove one entry");

    // No item is taken while the accepted one is in its execute state.
    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("item accepted during execute cycle");

endmodule

// ===== dv/post_wait_match_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// post_wait_match_table_tb
// Self-checking testbench for the post/wait match table.
// ----------------------------------------------------------------------------
// A short table of directed items covers the empty and loaded table, extreme
// node and tag values, and every wait kind. It also covers a wait with no
// match and several matching entries. Random segments follow. They mix
// post-heavy, wait-heavy and balanced traffic over small node and tag pools,
// so that waits find matches. One segment fills the table past its depth.
// A shadow copy of the table predicts results not fixed in the directed
// table. Both channels idle in random bursts, and once the receiver holds
// off long enough to back up the input channel.
// ----------------------------------------------------------------------------
module post_wait_match_table_tb;

    localparam int HALF_PERIOD   = 10;
    localparam int SEGMENT_ITEMS = 25;
    localparam int SEGMENTS      = 14;
    localparam int LONG_HOLD     = 120;
    localparam int DRAIN_CYCLES  = 10;
    localparam int MAX_REPORTS   = 10;
    localparam int N_DIRECTED    = 22;

    // Traffic mixes of the random segments.
    localparam int MIX_BALANCED = 0;
    localparam int MIX_POSTS    = 1;
    localparam int MIX_WAITS    = 2;
    localparam int MIX_FILL     = 3;

    typedef struct packed {
        pwm_pkg::status_t status;
        logic [6:0]       held;
    } table_result_t;

    typedef struct packed {
        pwm_pkg::op_t     op;
        logic [15:0]      node;
        logic [31:0]      tag;
        logic             fixed;
        pwm_pkg::status_t status;
        logic [6:0]       held;
    } stim_row_t;

    // Directed items; rows with fixed set carry their expected result.
    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{pwm_pkg::OP_WAIT_ANY, 16'h0000, 32'h0000_0000, 1'b1, pwm_pkg::ST_NONE, 7'd0},
        '{pwm_pkg::OP_WAIT_NODE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, pwm_pkg::ST_NONE, 7'd0},
        '{pwm_pkg::OP_WAIT_NODE_TAG, 16'h0000, 32'h0000_0000, 1'b1, pwm_pkg::ST_NONE, 7'd0},
        '{pwm_pkg::OP_POST, 16'hFFFF, 32'h7FFF_FFFF, 1'b1, pwm_pkg::ST_DONE, 7'd1},
        '{pwm_pkg::OP_POST, 16'h0000, 32'h8000_0000, 1'b1, pwm_pkg::ST_DONE, 7'd2},
        '{pwm_pkg::OP_POST, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, pwm_pkg::ST_DONE, 7'd3},
        '{pwm_pkg::OP_POST, 16'h0000, 32'h0000_0000, 1'b1, pwm_pkg::ST_DONE, 7'd4},
        '{pwm_pkg::OP_WAIT_NODE_TAG, 16'hFFFF, 32'h7FFF_FFFF, 1'b1, pwm_pkg::ST_DONE, 7'd3},
        '{pwm_pkg::OP_WAIT_NODE_TAG, 16'hFFFF, 32'h7FFF_FFFF, 1'b1, pwm_pkg::ST_NONE, 7'd3},
        '{pwm_pkg::OP_WAIT_NODE_TAG, 16'h0000, 32'hFFFF_FFFF, 1'b1, pwm_pkg::ST_NONE, 7'd3},
        '{pwm_pkg::OP_POST, 16'hFFFF, 32'h1234_5678, 1'b0, pwm_pkg::ST_DONE, 7'd0},
        '{pwm_pkg::OP_WAIT_NODE, 16'hFFFF, 32'h0000_0000, 1'b0, pwm_pkg::ST_DONE, 7'd0},
        '{pwm_pkg::OP_WAIT_NODE_TAG, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, pwm_pkg::ST_DONE, 7'd2},
        '{pwm_pkg::OP_WAIT_NODE, 16'h5A5A, 32'h0000_0000, 1'b0, pwm_pkg::ST_DONE, 7'd0},
        '{pwm_pkg::OP_POST, 16'h5A5A, 32'hA5A5_A5A5, 1'b0, pwm_pkg::ST_DONE, 7'd0},
        '{pwm_pkg::OP_POST, 16'h5A5A, 32'hA5A5_A5A5, 1'b0, pwm_pkg::ST_DONE, 7'd0},
        '{pwm_pkg::OP_WAIT_NODE_TAG, 16'h5A5A, 32'hA5A5_A5A5, 1'b0, pwm_pkg::ST_DONE, 7'd0},
        '{pwm_pkg::OP_WAIT_ANY, 16'h1234, 32'h0000_0000, 1'b1, pwm_pkg::ST_DONE, 7'd2},
        '{pwm_pkg::OP_WAIT_NODE, 16'h5A5A, 32'h0000_0000, 1'b1, pwm_pkg::ST_NONE, 7'd2},
        '{pwm_pkg::OP_WAIT_ANY, 16'h0000, 32'h0000_0000, 1'b1, pwm_pkg::ST_DONE, 7'd1},
        '{pwm_pkg::OP_WAIT_ANY, 16'h0000, 32'h0000_0000, 1'b1, pwm_pkg::ST_DONE, 7'd0},
        '{pwm_pkg::OP_WAIT_ANY, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, pwm_pkg::ST_NONE, 7'd0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic [15:0] s_node;
    logic [31:0] s_tag;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [6:0]  m_entries_held;

    // Shadow copy of the table.
    logic [15:0] shadow_node [pwm_pkg::TABLE_DEPTH];
    logic [31:0] shadow_tag  [pwm_pkg::TABLE_DEPTH];
    int          shadow_count;

    table_result_t due_results [$];
    int            mismatches;

    // Expectation attached to the item on the bus.
    bit            cur_fixed;
    table_result_t cur_result;

    // Idling controls for the two sides.
    bit sender_idles;
    bit receiver_idles;
    bit long_hold_req;

    // Value pools that make waits find their posts.
    logic [15:0] node_pool [4];
    logic [31:0] tag_pool  [4];

    post_wait_match_table DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_node         (s_node),
        .s_tag          (s_tag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_entries_held (m_entries_held)
    );

    // Clock generation.
    always begin
        aclk = 1'b0;
        #HALF_PERIOD;
        aclk = 1'b1;
        #HALF_PERIOD;
    end

    // Apply one item to the shadow table and return the result it causes.
    function automatic table_result_t match_table_step(pwm_pkg::op_t op, logic [15:0] node,
                                                       logic [31:0] tag);
        table_result_t r;
        int            hit;
        int            k;
        r.status = pwm_pkg::ST_DONE;
        hit      = -1;
        case (op)
            pwm_pkg::OP_POST: begin
                if (shadow_count >= pwm_pkg::TABLE_DEPTH) begin
                    r.status = pwm_pkg::ST_FULL;
                end else begin
                    shadow_node[shadow_count] = node;
                    shadow_tag[shadow_count]  = tag;
                    shadow_count++;
                end
            end
            pwm_pkg::OP_WAIT_ANY: begin
                if (shadow_count > 0)
                    shadow_count--;
                else
                    r.status = pwm_pkg::ST_NONE;
            end
            default: begin
                // Search from the newest entry down.
                for (k = shadow_count - 1; k >= 0; k--) begin
                    if (hit < 0 && shadow_node[k] == node &&
                        (op != pwm_pkg::OP_WAIT_NODE_TAG || shadow_tag[k] == tag))
                        hit = k;
                end
                if (hit < 0) begin
                    r.status = pwm_pkg::ST_NONE;
                end else begin
                    for (k = hit + 1; k < shadow_count; k++) begin
                        shadow_node[k - 1] = shadow_node[k];
                        shadow_tag[k - 1]  = shadow_tag[k];
                    end
                    shadow_count--;
                end
            end
        endcase
        r.held = shadow_count[6:0];
        return r;
    endfunction

    // Monitor: check finished items, then predict newly accepted ones.
    always @(posedge aclk) begin
        table_result_t exp_r;
        table_result_t pred_r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result item with none expected: status %0d held %0d",
                                 $realtime, m_status, m_entries_held);
                end else begin
                    exp_r = due_results.pop_front();
                    if (m_status != exp_r.status || m_entries_held != exp_r.held) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: status exp %0d got %0d, held exp %0d got %0d",
                                     $realtime, exp_r.status, m_status, exp_r.held,
                                     m_entries_held);
                    end
                end
            end
            if (s_valid && s_ready) begin
                pred_r = match_table_step(pwm_pkg::op_t'(s_operation), s_node, s_tag);
                due_results.push_back(cur_fixed ? cur_result : pred_r);
            end
        end
    end

    // Receiver: random stalls, plus one long hold on request.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left == 0) begin
                if (long_hold_req) begin
                    long_hold_req = 1'b0;
                    stall_left    = LONG_HOLD;
                end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
                    stall_left = $urandom_range(1, 15);
                end
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one item and wait for it to be taken; may idle afterwards.
    task automatic send_item(pwm_pkg::op_t op, logic [15:0] node, logic [31:0] tag,
                             bit fixed, table_result_t fixed_r);
        cur_fixed   = fixed;
        cur_result  = fixed_r;
        s_valid     <= 1'b1;
        s_operation <= op;
        s_node      <= node;
        s_tag       <= tag;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
    endtask

    // Draw one random item for the given traffic mix.
    task automatic send_random(int mix);
        pwm_pkg::op_t op;
        logic [15:0]  node;
        logic [31:0]  tag;
        int           pick;
        pick = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  op = pwm_pkg::OP_POST;
            MIX_POSTS: op = (pick < 75) ? pwm_pkg::OP_POST : pwm_pkg::op_t'($urandom_range(1, 3));
            MIX_WAITS: op = (pick < 25) ? pwm_pkg::OP_POST : pwm_pkg::op_t'($urandom_range(1, 3));
            default:   op = pwm_pkg::op_t'($urandom_range(0, 3));
        endcase
        node = ($urandom_range(0, 9) < 7) ? node_pool[$urandom_range(0, 3)]
                                          : 16'($urandom());
        tag  = ($urandom_range(0, 9) < 6) ? tag_pool[$urandom_range(0, 3)] : $urandom();
        send_item(op, node, tag, 1'b0, '0);
    endtask

    task automatic refresh_pools();
        int i;
        for (i = 0; i < 4; i++) begin
            node_pool[i] = 16'($urandom());
            tag_pool[i]  = $urandom();
        end
    endtask

    // Reset, stimulus and end of run.
    initial begin
        int            i;
        int            s;
        int            mix;
        table_result_t fixed_r;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_operation    = pwm_pkg::OP_POST;
        s_node         = '0;
        s_tag          = '0;
        cur_fixed      = 1'b0;
        cur_result     = '0;
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        long_hold_req  = 1'b0;
        shadow_count   = 0;
        mismatches     = 0;
        refresh_pools();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table, with light idling on both sides.
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        for (i = 0; i < N_DIRECTED; i++) begin
            fixed_r.status = DIRECTED_ROWS[i].status;
            fixed_r.held   = DIRECTED_ROWS[i].held;
            send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].node, DIRECTED_ROWS[i].tag,
                      DIRECTED_ROWS[i].fixed, fixed_r);
        end

        // Random segments; one of them overfills the table.
        for (s = 0; s < SEGMENTS; s++) begin
            refresh_pools();
            mix = $urandom_range(MIX_BALANCED, MIX_WAITS);
            if (s >= SEGMENTS - 2) begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end else begin
                sender_idles   = ($urandom_range(0, 3) != 0);
                receiver_idles = ($urandom_range(0, 3) != 0);
            end
            if (s == 3)
                long_hold_req = 1'b1;
            if (s == 6) begin
                // Post past the depth so that posts get rejected, then drain some.
                for (i = 0; i < pwm_pkg::TABLE_DEPTH + 6; i++)
                    send_random(MIX_FILL);
                mix = MIX_WAITS;
            end
            for (i = 0; i < SEGMENT_ITEMS; i++)
                send_random(mix);
        end
        s_valid <= 1'b0;

        // Let the last results arrive, then allow for stray ones.
        while (due_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        mismatches += due_results.size();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pwm_pkg.sv
rtl/pwm_cell.sv
rtl/post_wait_match_table.sv
dv/post_wait_match_table_tb.sv
